@@ hdl/hahs_pkg.sv @@
// shared types and constants for the health aware host selector
package hahs_pkg;

    localparam int MAX_HOSTS = 16;
    localparam int TIME_BITS = 32;
    localparam int ID_W      = $clog2(MAX_HOSTS);
    localparam int CNT_W     = ID_W + 1;

    localparam logic [1:0] REQ_SELECT  = 2'd0;
    localparam logic [1:0] REQ_SUCCESS = 2'd1;
    localparam logic [1:0] REQ_FAIL    = 2'd2;
    localparam logic [1:0] REQ_ALL_UP  = 2'd3;

    localparam logic [1:0] MODE_RANDOM = 2'd0;
    localparam logic [1:0] MODE_RR     = 2'd1;
    localparam logic [1:0] MODE_STICKY = 2'd2;

    localparam logic [2:0] CFG_HOST_COUNT = 3'd0;
    localparam logic [2:0] CFG_UNLIMITED  = 3'd1;
    localparam logic [2:0] CFG_LIMIT      = 3'd2;
    localparam logic [2:0] CFG_EXP        = 3'd3;
    localparam logic [2:0] CFG_FIXED      = 3'd4;
    localparam logic [2:0] CFG_MAX        = 3'd5;
    localparam logic [2:0] CFG_RESET_ALL  = 3'd6;

    // per-cell command, broadcast along the row
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_SET_ALIVE,
        CMD_FAIL,
        CMD_ALL_ALIVE,
        CMD_PROBE
    } cell_cmd_e;

    typedef struct packed {
        cell_cmd_e            cmd;
        logic [ID_W-1:0]      target;
        logic [TIME_BITS-1:0] now;
        logic                 exp;
        logic [15:0]          fixed_iv;
        logic [15:0]          max_iv;
    } cell_ctl_t;

    // status of one host seen by the sequencer
    typedef struct packed {
        logic alive;
        logic probe_ok;
    } cell_stat_t;

    typedef struct packed {
        logic                 unlimited;
        logic [7:0]           limit;
        logic [TIME_BITS-1:0] now;
    } cell_chk_t;

endpackage

@@ hdl/hahs_cell.sv @@
// one host entry: health flags, retry counter, delay and next-retry time
module hahs_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [hahs_pkg::ID_W-1:0] my_id,
    input  logic                in_pool,
    input  hahs_pkg::cell_ctl_t ctl,
    input  hahs_pkg::cell_chk_t chk,
    output hahs_pkg::cell_stat_t stat
);
    import hahs_pkg::*;

    logic                 alive_reg;
    logic [7:0]           cnt_reg;
    logic [15:0]          delay_reg;
    logic [TIME_BITS-1:0] next_reg;
    logic [16:0]          dbl;
    logic [15:0]          new_delay;
    logic                 hit;

    assign hit = (ctl.target == my_id);
    assign dbl = {delay_reg, 1'b0};
    always_comb
    begin
        if (ctl.exp)
            new_delay = (dbl > {1'b0, ctl.max_iv}) ? ctl.max_iv : dbl[15:0];
        else
            new_delay = ctl.fixed_iv;
    end

    assign stat.alive    = alive_reg;
    assign stat.probe_ok = (chk.unlimited || cnt_reg <= chk.limit) && (next_reg < chk.now);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alive_reg <= 1'b1;
            cnt_reg   <= '0;
            delay_reg <= '0;
            next_reg  <= '0;
        end
        else
        begin
            unique case (ctl.cmd)
                CMD_SET_ALIVE: if (hit) alive_reg <= 1'b1;
                CMD_ALL_ALIVE: if (in_pool) alive_reg <= 1'b1;
                CMD_FAIL:
                    if (hit && alive_reg)
                    begin
                        alive_reg <= 1'b0;
                        cnt_reg   <= '0;
                        delay_reg <= {15'd0, ctl.exp};
                        next_reg  <= ctl.now + TIME_BITS'(ctl.exp);
                    end
                CMD_PROBE:
                    if (hit)
                    begin
                        if (cnt_reg != 8'hff) cnt_reg <= cnt_reg + 8'd1;
                        delay_reg <= new_delay;
                        next_reg  <= ctl.now + TIME_BITS'(new_delay);
                    end
                default: ;
            endcase
        end
    end
endmodule

@@ hdl/hahs_row.sv @@
// row of host cells; the current host's status is muxed out to the sequencer
module hahs_row (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [hahs_pkg::CNT_W-1:0] n,
    input  hahs_pkg::cell_ctl_t ctl,
    input  hahs_pkg::cell_chk_t chk,
    input  logic [hahs_pkg::ID_W-1:0] sel,
    output hahs_pkg::cell_stat_t stat
);
    import hahs_pkg::*;

    cell_stat_t st [MAX_HOSTS];
    cell_stat_t pick;

    for (genvar g = 0; g < MAX_HOSTS; g++)
    begin : g_cell
        hahs_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .my_id  (ID_W'(g)),
            .in_pool(CNT_W'(g) < n),
            .ctl    (ctl),
            .chk    (chk),
            .stat   (st[g])
        );
    end

    assign pick = st[sel];
    assign stat = pick;
endmodule

@@ hdl/health_aware_host_selector_core.sv @@
// top level of the health aware host selector
// usage:
//  - input channel (in_valid/in_stall) takes one request transaction;
//    requests 1..3 update host flags and give no result
//  - a select walks the pool one host per cycle, but for the re-randomize
//    after a rejected random pick (at most host_count checks, clamped to
//    1..16); a random word is reduced modulo that count by a restoring
//    remainder, once for the first pick and once more for the re-randomize
//    after a rejected first random pick
//  - sequential, one transaction in flight; the next request is taken in the
//    cycle after the result goes out
//  - events are done in the cycle they are taken, one per cycle while idle
//  - the result sits in an output register held while out_stall is high;
//    the block waits there until the transaction goes out
//  - config (cfg_valid/cfg_ready) is always ready; write only when idle
//  - reset: all hosts alive, counters zero, no current host or sticky tag
module health_aware_host_selector_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [1:0]  select_mode,
    input  logic [31:0] message_tag,
    input  logic [7:0]  random_first,
    input  logic [7:0]  random_second,
    input  logic [31:0] now_seconds,
    input  logic [3:0]  host_id,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  selected_host,
    output logic        host_found,
    output logic        is_retry_probe,
    output logic        pool_was_reset,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import hahs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_MOD1, S_CHECK, S_MOD2, S_RESET, S_OUT
    } state_e;

    state_e state_reg;
    logic [4:0]  hc_reg;
    logic        unl_reg, exp_reg, rall_reg;
    logic [7:0]  lim_reg;
    logic [15:0] fix_reg, max_reg;

    logic [1:0]  mode_reg;
    logic [31:0] now_reg;
    logic [7:0]  r2_reg;
    logic [8:0]  rem_reg;
    logic [2:0]  mstep_reg;
    logic [CNT_W-1:0] walk_reg;
    logic [ID_W-1:0]  cur_reg;
    logic        curv_reg, stv_reg;
    logic [31:0] stag_reg;
    logic [ID_W-1:0] res_host_reg;
    logic        res_found_reg, res_probe_reg, res_reset_reg;

    cell_ctl_t  ctl;
    cell_chk_t  chk;
    cell_stat_t stat;
    logic [CNT_W-1:0] n;
    logic [ID_W-1:0]  rr_next;
    logic [12:0] sub;
    logic [8:0]  rem_dif;
    logic [ID_W-1:0]  mod_succ;

    assign n = (hc_reg == 5'd0) ? CNT_W'(1)
             : (hc_reg > 5'(MAX_HOSTS)) ? CNT_W'(MAX_HOSTS) : CNT_W'(hc_reg);

    // round robin successor of current host
    assign rr_next = (!curv_reg || {1'b0, cur_reg} + CNT_W'(1) >= n)
                   ? '0 : cur_reg + ID_W'(1);

    // restoring remainder, divisor shifted 7..0, one step per cycle
    assign sub     = {8'd0, n} << (3'd7 - mstep_reg);
    assign rem_dif = ({4'd0, rem_reg} >= sub) ? rem_reg - sub[8:0] : rem_reg;

    // round robin successor of the reduced random word
    assign mod_succ = ({1'b0, rem_dif[ID_W-1:0]} + CNT_W'(1) >= n)
                    ? '0 : rem_dif[ID_W-1:0] + ID_W'(1);

    assign chk.unlimited = unl_reg;
    assign chk.limit     = lim_reg;
    assign chk.now       = now_reg;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign selected_host  = res_host_reg;
    assign host_found     = res_found_reg;
    assign is_retry_probe = res_probe_reg;
    assign pool_was_reset = res_reset_reg;

    hahs_row u_row (
        .clk  (clk),
        .rst_n(rst_n),
        .n    (n),
        .ctl  (ctl),
        .chk  (chk),
        .sel  (cur_reg),
        .stat (stat)
    );

    // cell commands, combinational from state and the input request
    always_comb
    begin
        ctl.cmd      = CMD_NONE;
        ctl.target   = cur_reg;
        ctl.now      = now_reg;
        ctl.exp      = exp_reg;
        ctl.fixed_iv = fix_reg;
        ctl.max_iv   = max_reg;
        if (state_reg == S_IDLE && in_valid)
        begin
            ctl.target = host_id;
            ctl.now    = now_seconds;
            if (req_type == REQ_SUCCESS && {1'b0, host_id} < n) ctl.cmd = CMD_SET_ALIVE;
            else if (req_type == REQ_FAIL && {1'b0, host_id} < n) ctl.cmd = CMD_FAIL;
            else if (req_type == REQ_ALL_UP) ctl.cmd = CMD_ALL_ALIVE;
        end
        else if (state_reg == S_CHECK && !stat.alive && stat.probe_ok)
            ctl.cmd = CMD_PROBE;
        else if (state_reg == S_RESET)
            ctl.cmd = CMD_ALL_ALIVE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hc_reg <= 5'd1; unl_reg <= 1'b0; lim_reg <= '0; exp_reg <= 1'b0;
            fix_reg <= '0; max_reg <= '0; rall_reg <= 1'b0;
            state_reg <= S_IDLE;
            cur_reg <= '0; curv_reg <= 1'b0; stv_reg <= 1'b0; stag_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_HOST_COUNT: hc_reg   <= cfg_data[4:0];
                    CFG_UNLIMITED:  unl_reg  <= cfg_data[0];
                    CFG_LIMIT:      lim_reg  <= cfg_data[7:0];
                    CFG_EXP:        exp_reg  <= cfg_data[0];
                    CFG_FIXED:      fix_reg  <= cfg_data;
                    CFG_MAX:        max_reg  <= cfg_data;
                    CFG_RESET_ALL:  rall_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                    if (in_valid && req_type == REQ_SELECT)
                    begin
                        mode_reg <= (select_mode == MODE_RR || select_mode == MODE_STICKY)
                                  ? select_mode : MODE_RANDOM;
                        now_reg  <= now_seconds;
                        r2_reg   <= random_second;
                        rem_reg  <= {1'b0, random_first};
                        mstep_reg <= '0;
                        walk_reg <= '0;
                        if (select_mode == MODE_RR)
                        begin
                            cur_reg <= rr_next; curv_reg <= 1'b1; state_reg <= S_CHECK;
                        end
                        else if (select_mode == MODE_STICKY)
                        begin
                            if (!stv_reg || stag_reg != message_tag || !curv_reg
                                || {1'b0, cur_reg} >= n)
                            begin
                                stag_reg <= message_tag; stv_reg <= 1'b1;
                                cur_reg <= rr_next; curv_reg <= 1'b1;
                            end
                            state_reg <= S_CHECK;
                        end
                        else
                            state_reg <= S_MOD1;
                    end
                S_MOD1, S_MOD2:
                begin
                    rem_reg   <= rem_dif;
                    mstep_reg <= mstep_reg + 3'd1;
                    if (mstep_reg == 3'd7)
                    begin
                        // after the re-randomize the walk steps on round robin
                        cur_reg   <= (state_reg == S_MOD2) ? mod_succ : rem_dif[ID_W-1:0];
                        curv_reg  <= 1'b1;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (stat.alive || stat.probe_ok)
                    begin
                        res_host_reg <= cur_reg; res_found_reg <= 1'b1;
                        res_probe_reg <= !stat.alive; res_reset_reg <= 1'b0;
                        state_reg <= S_OUT;
                    end
                    else if (walk_reg + CNT_W'(1) >= n)
                    begin
                        if (rall_reg) state_reg <= S_RESET;
                        else
                        begin
                            res_host_reg <= '0; res_found_reg <= 1'b0;
                            res_probe_reg <= 1'b0; res_reset_reg <= 1'b0;
                            state_reg <= S_OUT;
                        end
                    end
                    else
                    begin
                        walk_reg <= walk_reg + CNT_W'(1);
                        if (mode_reg == MODE_RANDOM)
                        begin
                            // re-randomize, then the next step is round robin
                            rem_reg <= {1'b0, r2_reg}; mstep_reg <= '0;
                            mode_reg <= MODE_RR;
                            state_reg <= S_MOD2;
                        end
                        else
                            cur_reg <= rr_next;
                    end
                end
                S_RESET:
                begin
                    cur_reg <= rr_next; curv_reg <= 1'b1;
                    res_host_reg <= rr_next; res_found_reg <= 1'b1;
                    res_probe_reg <= 1'b0; res_reset_reg <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT:
                    if (!out_stall) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // the result holds while the receiver stalls
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(selected_host))
        else $error("result changed under stall");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("input open during result");
    a_walk: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CHECK |-> walk_reg < n) else $error("walk overran pool");
    a_none: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !host_found |-> !is_retry_probe && !pool_was_reset)
        else $error("flags set without host");
endmodule
